[rtl/core/tbb_pkg.sv]
// Shared constants, types and register codes for the transformed bounding box unit.
package tbb_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int COEF_BITS  = 16;
  localparam int AXES       = 3;
  localparam int TERMS      = 3;
  localparam int RES_W      = 32;
  localparam int ROW_W      = 4 * COEF_BITS;

  localparam int PROD_W     = COORD_BITS + COEF_BITS;
  localparam int ACC_W      = PROD_W + 2;
  localparam int EXT_W      = (ACC_W + 1 > RES_W + 1) ? ACC_W + 1 : RES_W + 1;

  localparam int IN_DATA_W  = ((AXES * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 4 * AXES * RES_W;

  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 2'd2;

  localparam logic [ROW_W-1:0] ROW_X_RST = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 64'h0000_0100_0000_0000;

  localparam logic [RES_W-1:0] BOX_LO_RST = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] BOX_HI_RST = {1'b1, {(RES_W-1){1'b0}}};

  // one transformed vertex on its way from front to back
  typedef struct packed {
    logic                             last;
    logic [AXES-1:0][RES_W-1:0]       coord;
  } vtx_t;

  typedef struct packed {
    logic                             valid;
    vtx_t                             vtx;
  } q_push_t;

  typedef struct packed {
    logic                             valid;
    logic [QCNT_W-1:0]                count;
    vtx_t                             head;
  } q_stat_t;

  // packed so that min_x lands in the lowest bits
  typedef struct packed {
    logic [AXES-1:0][RES_W-1:0]       center;
    logic [AXES-1:0][RES_W-1:0]       size;
    logic [AXES-1:0][RES_W-1:0]       hi;
    logic [AXES-1:0][RES_W-1:0]       lo;
  } box_t;

endpackage

[rtl/core/transformed_bounding_box_unit.sv]
// Transformed bounding box unit: affine-transforms vertices and reports their box.
//
// Vertices enter as signed Q8.8 x/y/z, are transformed by the three configured
// affine rows (floor shift by 8 after the product sum, then translation) and
// folded into a running per-axis min/max. The word with in_tlast set is folded
// in, then min, max, size and center per axis are presented as one output word
// and the box returns to empty. One vertex is accepted per clock while the
// queue has room; the rate is set by the min/max fold in the back end, which
// takes one queued word a cycle. A vertex passes the product stage, the sum
// stage and the queue write before it is folded into the box; for a final
// vertex the result register loads on the edge that folds it in, raising
// out_tvalid. The back end only waits when a final word finds the previous
// result still untaken; in_tready drops once queued and in-flight words fill
// the four-entry queue. Matrix rows are written through the cfg port; the user
// must write them only while the unit is idle; the block does not enforce it.
module transformed_bounding_box_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pos_x, pos_y, pos_z
  input  logic [tbb_pkg::IN_DATA_W-1:0]      in_tdata,
  // final_vertex
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // min_x..z, max_x..z, size_x..z, center_x..z, 32 bits each
  output logic [tbb_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tbb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbb_pkg::ROW_W-1:0]          cfg_data
);
  import tbb_pkg::*;

  q_push_t  q_push;
  q_stat_t  q_stat;
  logic     q_pop;

  assign cfg_ready = 1'b1;

  tbb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_count   (q_stat.count),
    .q_push    (q_push)
  );

  tbb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_stat (q_stat)
  );

  tbb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/core/tbb_front.sv]
// Front end: matrix registers, vertex intake and the two-stage affine transform.
module tbb_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tbb_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,
  input  logic                             cfg_valid,
  input  logic [tbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbb_pkg::ROW_W-1:0]        cfg_data,
  input  logic [tbb_pkg::QCNT_W-1:0]       q_count,
  output tbb_pkg::q_push_t                 q_push
);
  import tbb_pkg::*;

  logic [AXES-1:0][ROW_W-1:0]                          row_r;
  logic                                                v1_r, v2_r;
  logic                                                last1_r;
  logic signed [PROD_W-1:0]                            prod_r [AXES][TERMS];
  vtx_t                                                vtx2_r;
  logic [AXES-1:0][RES_W-1:0]                          coord_nxt;
  logic [QCNT_W:0]                                     pending;
  logic                                                accept;

  // words in flight plus words queued must fit the queue
  assign pending   = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(v1_r) + (QCNT_W+1)'(v2_r);
  assign in_tready = (pending < (QCNT_W+1)'(QDEPTH));
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW_X_RST;
      row_r[1] <= ROW_Y_RST;
      row_r[2] <= ROW_Z_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_X: row_r[0] <= cfg_data;
        CFG_ROW_Y: row_r[1] <= cfg_data;
        CFG_ROW_Z: row_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: nine products
  always_ff @(posedge clk) begin
    if (accept) begin
      last1_r <= in_tlast;
      for (int a = 0; a < AXES; a++) begin
        for (int k = 0; k < TERMS; k++) begin
          prod_r[a][k] <= PROD_W'($signed(in_tdata[k*COORD_BITS +: COORD_BITS]) *
                                  $signed(row_r[a][k*COEF_BITS +: COEF_BITS]));
        end
      end
    end
  end

  // stage 2: sum, floor shift, translate, clamp to 32 bits
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    logic signed [EXT_W-1:0] sum;
    for (int a = 0; a < AXES; a++) begin
      acc = ACC_W'(prod_r[a][0]) + ACC_W'(prod_r[a][1]) + ACC_W'(prod_r[a][2]);
      shifted = acc >>> FRAC_BITS;
      sum = EXT_W'(shifted) + EXT_W'($signed(row_r[a][3*COEF_BITS +: COEF_BITS]));
      if (sum[EXT_W-1:RES_W-1] == {(EXT_W-RES_W+1){1'b0}} ||
          sum[EXT_W-1:RES_W-1] == {(EXT_W-RES_W+1){1'b1}}) begin
        coord_nxt[a] = sum[RES_W-1:0];
      end else if (sum[EXT_W-1]) begin
        coord_nxt[a] = BOX_HI_RST;
      end else begin
        coord_nxt[a] = BOX_LO_RST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      vtx2_r.last  <= last1_r;
      vtx2_r.coord <= coord_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  assign q_push.valid = v2_r;
  assign q_push.vtx   = vtx2_r;

endmodule

[rtl/core/tbb_queue.sv]
// Short queue of transformed vertices between the front and back ends.
module tbb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbb_pkg::q_push_t     q_push,
  input  logic                 q_pop,
  output tbb_pkg::q_stat_t     q_stat
);
  import tbb_pkg::*;

  vtx_t               q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_pop;

  assign do_pop = q_pop && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (q_push.valid && !do_pop) count_nxt = count_r + 1'b1;
    else if (!q_push.valid && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) q_mem_r[wr_ptr_r] <= q_push.vtx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)       rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign q_stat.valid = (count_r != '0);
  assign q_stat.count = count_r;
  assign q_stat.head  = q_mem_r[rd_ptr_r];

endmodule

[rtl/core/tbb_back.sv]
// Back end: running per-axis min/max and the result register.
module tbb_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tbb_pkg::q_stat_t                    q_stat,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tbb_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import tbb_pkg::*;

  logic [AXES-1:0][RES_W-1:0]  lo_r, hi_r, lo_nxt, hi_nxt;
  logic                        out_valid_r;
  box_t                        out_r, box_nxt;
  logic                        emit;

  // a final word needs the result register free
  assign q_pop = q_stat.valid &&
                 (!q_stat.head.last || !out_valid_r || out_tready);
  assign emit  = q_pop && q_stat.head.last;

  always_comb begin
    logic [RES_W:0] mid;
    for (int a = 0; a < AXES; a++) begin
      lo_nxt[a] = ($signed(q_stat.head.coord[a]) < $signed(lo_r[a])) ?
                  q_stat.head.coord[a] : lo_r[a];
      hi_nxt[a] = ($signed(q_stat.head.coord[a]) > $signed(hi_r[a])) ?
                  q_stat.head.coord[a] : hi_r[a];
      mid = (RES_W+1)'($signed(lo_nxt[a])) + (RES_W+1)'($signed(hi_nxt[a]));
      box_nxt.lo[a]     = lo_nxt[a];
      box_nxt.hi[a]     = hi_nxt[a];
      box_nxt.size[a]   = hi_nxt[a] - lo_nxt[a];
      box_nxt.center[a] = mid[RES_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= {AXES{BOX_LO_RST}};
      hi_r <= {AXES{BOX_HI_RST}};
    end else if (emit) begin
      lo_r <= {AXES{BOX_LO_RST}};
      hi_r <= {AXES{BOX_HI_RST}};
    end else if (q_pop) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= box_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

`ifndef ASSERT_OFF
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("result not presented after final word");

  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (lo_r[0] == BOX_LO_RST && hi_r[0] == BOX_HI_RST))
    else $error("box not cleared after final word");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_r.lo[0]) <= $signed(out_r.hi[0]) &&
                     $signed(out_r.lo[1]) <= $signed(out_r.hi[1]) &&
                     $signed(out_r.lo[2]) <= $signed(out_r.hi[2])))
    else $error("reported min above max");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.count != '0)
    else $error("pop from empty queue");
`endif

endmodule
